@@ sv/i2ce_pkg.sv @@
// Shared types and codes for the I2C EEPROM master.
`timescale 1ns / 1ps
package i2ce_pkg;
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_SPLIT = 3'd2;
    localparam logic [2:0] MODE_PAGE  = 3'd3;
    localparam logic [2:0] MODE_WBYTE = 3'd4;

    // Command as classified by the front part
    typedef struct packed {
        logic [2:0] mode;
        logic [8:0] mem_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       want_byte;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        logic [2:0] status;
    } result_t;
endpackage

@@ sv/i2ce_fifo.sv @@
// Short queue between the front and the back part.
`timescale 1ns / 1ps
module i2ce_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr, rd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= in_data;
    end
endmodule

@@ sv/i2ce_engine.sv @@
// Bus sequencer: one queued item is one tick, output held in a register.
`timescale 1ns / 1ps
module i2ce_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  i2ce_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output i2ce_pkg::result_t out_res,
    input  logic [6:0]       device_address,
    input  logic [7:0]       phase_ticks,
    input  logic [15:0]      write_wait_ticks
);
    import i2ce_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0, ST_START_A = 5'd1, ST_START_B = 5'd2,
        ST_TX_LOW = 5'd3, ST_TX_SET = 5'd4, ST_TX_HIGH = 5'd5, ST_ACK_LOW = 5'd6,
        ST_ACK_HIGH = 5'd7, ST_RX_LOW = 5'd8, ST_RX_HIGH = 5'd9, ST_MA_LOW = 5'd10,
        ST_MA_SET = 5'd11, ST_MA_HIGH = 5'd12, ST_STOP_A = 5'd13, ST_STOP_B = 5'd14,
        ST_WAIT = 5'd15, ST_NEED = 5'd16;
    localparam logic [2:0] SG_DEVW = 3'd0, SG_ADDR = 3'd1, SG_DEVR = 3'd2,
        SG_DATA = 3'd3, SG_READ = 3'd4;
    localparam logic [2:0] ERR_DEV = 3'd1, ERR_ADDR = 3'd2, ERR_DATA = 3'd3,
        ERR_PAGE = 3'd4;

    logic [4:0]  state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic [3:0]  bc_reg, bc_next;
    logic [7:0]  sh_reg, sh_next;
    logic [8:0]  addr_reg, addr_next;
    logic [7:0]  rem_reg, rem_next;
    logic [4:0]  page_reg, page_next;
    logic [2:0]  stat_reg, stat_next;
    logic [1:0]  job_reg, job_next;
    logic [2:0]  stage_reg, stage_next;
    logic        lvl_reg;
    logic        ov_reg;
    result_t     res_reg, res;
    logic        go;
    logic [15:0] pc_inc;
    logic [7:0]  pt;
    logic [4:0]  room;
    logic [8:0]  last_addr;
    logic        scl, sda, nack;

    assign in_ready  = !ov_reg || out_ready;
    assign go        = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    // Line levels of the current phase
    always_comb
    begin
        nack = (rem_reg == 8'd0);
        scl = 1'b1;
        sda = 1'b1;
        unique case (state_reg)
            ST_START_B, ST_STOP_A: begin scl = 1'b1; sda = 1'b0; end
            ST_TX_LOW, ST_MA_LOW, ST_NEED: begin scl = 1'b0; sda = lvl_reg; end
            ST_TX_SET: begin scl = 1'b0; sda = sh_reg[7]; end
            ST_TX_HIGH: begin scl = 1'b1; sda = sh_reg[7]; end
            ST_ACK_LOW, ST_RX_LOW: begin scl = 1'b0; sda = 1'b1; end
            ST_MA_SET: begin scl = 1'b0; sda = nack; end
            ST_MA_HIGH: begin scl = 1'b1; sda = nack; end
            default: begin scl = 1'b1; sda = 1'b1; end
        endcase
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg; pc_next = pc_reg; bc_next = bc_reg;
        sh_next = sh_reg; addr_next = addr_reg; rem_next = rem_reg;
        page_next = page_reg; stat_next = stat_reg; job_next = job_reg;
        stage_next = stage_reg;
        res = '0;
        pt = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
        pc_inc = pc_reg + 16'd1;
        room = 5'd16 - {1'b0, addr_reg[3:0]};
        last_addr = in_item.mem_address + {1'b0, in_item.byte_count} - 9'd1;
        res.want_byte = (state_reg == ST_NEED);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_item.mode == MODE_READ || in_item.mode == MODE_SPLIT ||
                    in_item.mode == MODE_PAGE)
                begin
                    if (in_item.byte_count == 8'd0)
                    begin
                        stat_next = 3'd0; pc_next = '0; res.done_res = 1'b1;
                    end
                    else if (in_item.mode == MODE_PAGE &&
                             (in_item.mem_address[8:4] != last_addr[8:4] ||
                              ({1'b0, in_item.mem_address} + {2'b0, in_item.byte_count}
                               - 10'd1) > 10'd511))
                    begin
                        stat_next = ERR_PAGE; pc_next = '0; res.done_res = 1'b1;
                    end
                    else
                    begin
                        job_next = in_item.mode[1:0];
                        addr_next = in_item.mem_address;
                        rem_next = in_item.byte_count;
                        stat_next = 3'd0;
                        room = 5'd16 - {1'b0, in_item.mem_address[3:0]};
                        page_next = ({3'b0, room} < in_item.byte_count) ? room
                                    : in_item.byte_count[4:0];
                        stage_next = SG_DEVW; state_next = ST_START_A; pc_next = '0;
                    end
                end
            end
            ST_NEED:
            begin
                if (in_item.mode == MODE_WBYTE)
                begin
                    sh_next = in_item.write_byte; bc_next = '0;
                    state_next = ST_TX_LOW; pc_next = '0;
                end
            end
            ST_WAIT:
            begin
                pc_next = pc_inc;
                if (pc_inc >= write_wait_ticks)
                begin
                    pc_next = '0;
                    if (rem_reg == 8'd0)
                    begin
                        stat_next = 3'd0; state_next = ST_IDLE; res.done_res = 1'b1;
                    end
                    else
                    begin
                        page_next = ({3'b0, room} < rem_reg) ? room : rem_reg[4:0];
                        stage_next = SG_DEVW; state_next = ST_START_A;
                    end
                end
            end
            default:
            begin
                pc_next = pc_inc;
                if (pc_inc >= {8'd0, pt})
                begin
                    pc_next = '0;
                    unique case (state_reg)
                        ST_START_A: state_next = ST_START_B;
                        ST_START_B:
                        begin
                            sh_next = {(device_address | {6'd0, addr_reg[8]}),
                                       (stage_reg == SG_DEVR)};
                            bc_next = '0; state_next = ST_TX_LOW;
                        end
                        ST_TX_LOW: state_next = ST_TX_SET;
                        ST_TX_SET: state_next = ST_TX_HIGH;
                        ST_TX_HIGH:
                        begin
                            sh_next = {sh_reg[6:0], 1'b0};
                            bc_next = bc_reg + 4'd1;
                            state_next = (bc_reg + 4'd1 >= 4'd8) ? ST_ACK_LOW : ST_TX_LOW;
                        end
                        ST_ACK_LOW: state_next = ST_ACK_HIGH;
                        ST_ACK_HIGH:
                        begin
                            if (in_item.sda_in)
                            begin
                                stat_next = (stage_reg == SG_ADDR) ? ERR_ADDR
                                          : (stage_reg == SG_DATA) ? ERR_DATA : ERR_DEV;
                                state_next = ST_STOP_A;
                            end
                            else
                            begin
                                case (stage_reg)
                                    SG_DEVW:
                                    begin
                                        stage_next = SG_ADDR; sh_next = addr_reg[7:0];
                                        bc_next = '0; state_next = ST_TX_LOW;
                                    end
                                    SG_ADDR:
                                    begin
                                        if (job_reg == MODE_READ[1:0])
                                        begin
                                            stage_next = SG_DEVR; state_next = ST_START_A;
                                        end
                                        else
                                        begin
                                            stage_next = SG_DATA; state_next = ST_NEED;
                                        end
                                    end
                                    SG_DEVR:
                                    begin
                                        stage_next = SG_READ; sh_next = '0;
                                        bc_next = '0; state_next = ST_RX_LOW;
                                    end
                                    default:
                                    begin
                                        if (rem_reg != 8'd0) rem_next = rem_reg - 8'd1;
                                        if (page_reg != 5'd0) page_next = page_reg - 5'd1;
                                        addr_next = addr_reg + 9'd1;
                                        state_next = (page_reg <= 5'd1) ? ST_STOP_A
                                                                         : ST_NEED;
                                    end
                                endcase
                            end
                        end
                        ST_RX_LOW: state_next = ST_RX_HIGH;
                        ST_RX_HIGH:
                        begin
                            sh_next = {sh_reg[6:0], in_item.sda_in};
                            bc_next = bc_reg + 4'd1;
                            if (bc_reg + 4'd1 >= 4'd8)
                            begin
                                res.read_valid = 1'b1;
                                res.read_data = {sh_reg[6:0], in_item.sda_in};
                                if (rem_reg != 8'd0) rem_next = rem_reg - 8'd1;
                                addr_next = addr_reg + 9'd1;
                                state_next = ST_MA_LOW;
                            end
                            else
                                state_next = ST_RX_LOW;
                        end
                        ST_MA_LOW: state_next = ST_MA_SET;
                        ST_MA_SET: state_next = ST_MA_HIGH;
                        ST_MA_HIGH:
                        begin
                            if (rem_reg == 8'd0)
                                state_next = ST_STOP_A;
                            else
                            begin
                                sh_next = '0; bc_next = '0; state_next = ST_RX_LOW;
                            end
                        end
                        ST_STOP_A: state_next = ST_STOP_B;
                        ST_STOP_B:
                        begin
                            if (stat_reg != 3'd0 || job_reg == MODE_READ[1:0])
                            begin
                                state_next = ST_IDLE; res.done_res = 1'b1;
                            end
                            else if (write_wait_ticks != 16'd0)
                                state_next = ST_WAIT;
                            else if (rem_reg == 8'd0)
                            begin
                                state_next = ST_IDLE; res.done_res = 1'b1;
                            end
                            else
                            begin
                                page_next = ({3'b0, room} < rem_reg) ? room
                                            : rem_reg[4:0];
                                stage_next = SG_DEVW; state_next = ST_START_A;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
        endcase
        res.scl = scl;
        res.sda_out = sda;
        res.busy_res = (state_next != ST_IDLE);
        res.status = stat_next;
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; pc_reg <= '0; bc_reg <= '0; sh_reg <= '0;
            addr_reg <= '0; rem_reg <= '0; page_reg <= '0; stat_reg <= '0;
            job_reg <= '0; stage_reg <= SG_DEVW; lvl_reg <= 1'b1; ov_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                state_reg <= state_next; pc_reg <= pc_next; bc_reg <= bc_next;
                sh_reg <= sh_next; addr_reg <= addr_next; rem_reg <= rem_next;
                page_reg <= page_next; stat_reg <= stat_next; job_reg <= job_next;
                stage_reg <= stage_next; lvl_reg <= sda;
            end
            if (go) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go) res_reg <= res;
    end
endmodule

@@ sv/i2c_eeprom_master.sv @@
// I2C EEPROM master top level: register port, tick queue and bus sequencer.
// Use: every input transfer on s_axis is one bus tick. Its tdata carries the
// tick mode (plain tick, start read, start split write, start page write,
// write byte), the start address, the byte count, the write byte and the
// sampled SDA level. Each tick yields exactly one result on m_axis with the
// driven SCL and SDA levels, busy, want-byte, read data and valid, done and
// status. A tick passes a two-entry queue and the sequencer, which registers
// its result, so a tick passes the queue entry and the result register on
// its way; one tick is taken per clock cycle while m_axis does not stall.
// Registers on the APB port: device address (0x0), ticks per bus phase (0x4)
// and write-cycle wait ticks (0x8); write them only while the bus is idle.
// Reset puts the bus idle with both lines released and restores register
// defaults. When m_axis stalls the result holds, the queue fills and
// s_axis_tready drops; no tick is lost.
`timescale 1ns / 1ps
module i2c_eeprom_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] mode, [11:3] mem_address, [19:12] byte_count, [27:20] write_byte,
    // [28] sda_in
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl, [1] sda_out, [2] busy_res, [3] want_byte, [11:4] read_data,
    // [12] read_valid, [13] done_res, [16:14] status
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2ce_pkg::*;

    localparam logic [3:0] REG_DEV = 4'h0, REG_PHASE = 4'h4, REG_WAIT = 4'h8;

    logic [6:0]  dev_reg;
    logic [7:0]  phase_reg;
    logic [15:0] wait_reg;
    item_t       item_in, item_q;
    logic        q_valid, q_ready;
    result_t     res;

    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= 7'd80; phase_reg <= 8'd5; wait_reg <= 16'd5000;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                REG_DEV:   dev_reg <= pwdata[6:0];
                REG_PHASE: phase_reg <= pwdata[7:0];
                REG_WAIT:  wait_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_DEV:   prdata = {25'd0, dev_reg};
            REG_PHASE: prdata = {24'd0, phase_reg};
            REG_WAIT:  prdata = {16'd0, wait_reg};
            default:   prdata = '0;
        endcase
    end

    // Front: unpack the tick
    assign item_in.mode        = s_axis_tdata[2:0];
    assign item_in.mem_address = s_axis_tdata[11:3];
    assign item_in.byte_count  = s_axis_tdata[19:12];
    assign item_in.write_byte  = s_axis_tdata[27:20];
    assign item_in.sda_in      = s_axis_tdata[28];

    i2ce_fifo #(.W($bits(item_t))) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(item_in),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(item_q)
    );

    i2ce_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(item_q),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res),
        .device_address(dev_reg), .phase_ticks(phase_reg),
        .write_wait_ticks(wait_reg)
    );

    assign m_axis_tdata = {7'd0, res.status, res.done_res, res.read_valid,
                           res.read_data, res.want_byte, res.busy_res,
                           res.sda_out, res.scl};

    // A finished transaction is never still busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.done_res |-> !res.busy_res)
        else $error("done while busy");
    // Read data valid only while busy
    a_rv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.read_valid |-> res.busy_res)
        else $error("read byte outside transaction");
    // A write byte is only wanted inside a transaction
    a_want_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.want_byte |-> res.busy_res)
        else $error("byte wanted while idle");
endmodule

@@ tb/tb.sv @@
// Testbench for the I2C EEPROM master: tick stream driven against a local bus-sequencer model.
`timescale 1ns / 1ps
module tb;
    import i2ce_pkg::*;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE, S_START_A, S_START_B, S_TX_LOW, S_TX_SET, S_TX_HIGH, S_ACK_LOW,
        S_ACK_HIGH, S_RX_LOW, S_RX_HIGH, S_MA_LOW, S_MA_SET, S_MA_HIGH,
        S_STOP_A, S_STOP_B, S_WAIT, S_NEED
    } seq_state_t;
    typedef enum logic [2:0] {G_DEVW, G_ADDR, G_DEVR, G_DATA, G_READ} stage_t;

    localparam logic [3:0] REG_DEV   = 4'h0;
    localparam logic [3:0] REG_PHASE = 4'h4;
    localparam logic [3:0] REG_WAIT  = 4'h8;
    localparam logic [2:0] ST_OK = 3'd0, ST_NODEV = 3'd1, ST_NOADDR = 3'd2,
                           ST_NODATA = 3'd3, ST_CROSS = 3'd4;
    localparam int LIMIT = 400000;

    logic        clk, rst_n;
    logic        s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [23:0] m_axis_tdata;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    i2c_eeprom_master dut (.*);

    // Model copy of registers and state
    logic [6:0]  m_dev;
    logic [7:0]  m_phase;
    logic [15:0] m_wait;
    seq_state_t  m_st;
    stage_t      m_stage;
    logic [15:0] m_pc;
    logic [3:0]  m_bits;
    logic [7:0]  m_sh;
    logic [8:0]  m_addr;
    logic [7:0]  m_rem;
    logic [4:0]  m_page;
    logic [2:0]  m_last, m_job;
    logic        m_sda;
    logic        ev_done, ev_rv;
    logic [7:0]  ev_rd;

    result_t     expected_q[$];
    int          errors, cycles, hold_cycles, rx_gap;
    bit          hold_rx;

    // Outcome knob for the random bus partner
    int          nack_pct;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---- predictor ----
    function automatic void m_finish(input logic [2:0] code);
        m_last = code; m_st = S_IDLE; m_pc = 0; ev_done = 1;
    endfunction

    function automatic void m_begin_page();
        logic [4:0] room;
        room = 5'd16 - {1'b0, m_addr[3:0]};
        m_page = (room < m_rem) ? room : m_rem[4:0];
        m_stage = G_DEVW; m_st = S_START_A; m_pc = 0;
    endfunction

    function automatic void m_load(input logic [7:0] b);
        m_sh = b; m_bits = 0; m_st = S_TX_LOW; m_pc = 0;
    endfunction

    function automatic void m_after_wait();
        if (m_rem == 0) m_finish(ST_OK);
        else m_begin_page();
    endfunction

    function automatic void m_end_phase(input logic sin);
        logic [6:0] d;
        case (m_st)
            S_START_A: m_st = S_START_B;
            S_START_B:
            begin
                d = m_dev | {6'd0, m_addr[8]};
                m_load({d, m_stage == G_DEVR});
            end
            S_TX_LOW: m_st = S_TX_SET;
            S_TX_SET: m_st = S_TX_HIGH;
            S_TX_HIGH:
            begin
                m_sh = m_sh << 1; m_bits++;
                m_st = (m_bits >= 8) ? S_ACK_LOW : S_TX_LOW;
            end
            S_ACK_LOW: m_st = S_ACK_HIGH;
            S_ACK_HIGH:
                if (sin)
                begin
                    m_last = (m_stage == G_ADDR) ? ST_NOADDR :
                             (m_stage == G_DATA) ? ST_NODATA : ST_NODEV;
                    m_st = S_STOP_A;
                end
                else case (m_stage)
                    G_DEVW: begin m_stage = G_ADDR; m_load(m_addr[7:0]); end
                    G_ADDR:
                        if (m_job == MODE_READ) begin m_stage = G_DEVR; m_st = S_START_A; end
                        else begin m_stage = G_DATA; m_st = S_NEED; end
                    G_DEVR: begin m_stage = G_READ; m_sh = 0; m_bits = 0; m_st = S_RX_LOW; end
                    default:
                    begin
                        if (m_rem > 0) m_rem--;
                        if (m_page > 0) m_page--;
                        m_addr = m_addr + 9'd1;
                        m_st = (m_page == 0) ? S_STOP_A : S_NEED;
                    end
                endcase
            S_RX_LOW: m_st = S_RX_HIGH;
            S_RX_HIGH:
            begin
                m_sh = {m_sh[6:0], sin}; m_bits++;
                if (m_bits >= 8)
                begin
                    ev_rv = 1; ev_rd = m_sh;
                    if (m_rem > 0) m_rem--;
                    m_addr = m_addr + 9'd1;
                    m_st = S_MA_LOW;
                end
                else m_st = S_RX_LOW;
            end
            S_MA_LOW: m_st = S_MA_SET;
            S_MA_SET: m_st = S_MA_HIGH;
            S_MA_HIGH:
                if (m_rem == 0) m_st = S_STOP_A;
                else begin m_sh = 0; m_bits = 0; m_st = S_RX_LOW; end
            S_STOP_A: m_st = S_STOP_B;
            S_STOP_B:
                if (m_last != 0) m_finish(m_last);
                else if (m_job == MODE_READ) m_finish(ST_OK);
                else if (m_wait == 0) m_after_wait();
                else m_st = S_WAIT;
            default: m_st = S_IDLE;
        endcase
    endfunction

    function automatic result_t predict_tick(input item_t it);
        result_t r;
        logic [7:0] pt;
        logic wanted, nack;
        pt = (m_phase != 0) ? m_phase : 8'd1;
        wanted = (m_st == S_NEED);
        nack = (m_rem == 0);
        ev_done = 0; ev_rv = 0; ev_rd = 0;
        r = '0;
        case (m_st)
            S_START_B, S_STOP_A: begin r.scl = 1; r.sda_out = 0; end
            S_TX_LOW, S_MA_LOW, S_NEED: begin r.scl = 0; r.sda_out = m_sda; end
            S_TX_SET: begin r.scl = 0; r.sda_out = m_sh[7]; end
            S_TX_HIGH: begin r.scl = 1; r.sda_out = m_sh[7]; end
            S_ACK_LOW, S_RX_LOW: begin r.scl = 0; r.sda_out = 1; end
            S_MA_SET: begin r.scl = 0; r.sda_out = nack; end
            S_MA_HIGH: begin r.scl = 1; r.sda_out = nack; end
            default: begin r.scl = 1; r.sda_out = 1; end
        endcase
        if (m_st == S_IDLE)
        begin
            if (it.mode >= MODE_READ && it.mode <= MODE_PAGE)
            begin
                if (it.byte_count == 0) m_finish(ST_OK);
                else if (it.mode == MODE_PAGE &&
                         it.mem_address[8:4] != 5'((10'(it.mem_address) +
                         10'(it.byte_count) - 10'd1) >> 4))
                    m_finish(ST_CROSS);
                else
                begin
                    m_job = it.mode; m_addr = it.mem_address; m_rem = it.byte_count;
                    m_last = 0; m_begin_page();
                end
            end
        end
        else if (m_st == S_NEED)
        begin
            if (it.mode == MODE_WBYTE) m_load(it.write_byte);
        end
        else if (m_st == S_WAIT)
        begin
            m_pc = m_pc + 16'd1;
            if (m_pc >= m_wait) begin m_pc = 0; m_after_wait(); end
        end
        else
        begin
            m_pc = m_pc + 16'd1;
            if (m_pc >= 16'(pt)) begin m_pc = 0; m_end_phase(it.sda_in); end
        end
        m_sda = r.sda_out;
        r.busy_res = (m_st != S_IDLE);
        r.want_byte = wanted;
        r.read_data = ev_rd;
        r.read_valid = ev_rv;
        r.done_res = ev_done;
        r.status = m_last;
        return r;
    endfunction

    // ---- stimulus ----
    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 60) return;
        g = (g < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        s_axis_tvalid <= 0;
        repeat (g) @(posedge clk);
    endtask

    task automatic send_tick(input item_t it, input bit gaps);
        if (gaps) idle_gap();
        s_axis_tvalid <= 1;
        s_axis_tdata <= {3'd0, it.sda_in, it.write_byte, it.byte_count,
                         it.mem_address, it.mode};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_q.push_back(predict_tick(it));
    endtask

    // Bus partner: answer according to the model's current state
    function automatic item_t bus_tick(input logic [7:0] wb);
        item_t it;
        it = '0;
        it.mode = (m_st == S_NEED) ? MODE_WBYTE : MODE_TICK;
        it.write_byte = wb;
        if (m_st == S_ACK_HIGH || m_st == S_ACK_LOW)
            it.sda_in = ($urandom_range(0, 99) < nack_pct);
        else
            it.sda_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic run_command(input logic [2:0] mode, input logic [8:0] a,
                               input logic [7:0] n, input bit gaps);
        item_t it;
        int guard;
        it = '0; it.mode = mode; it.mem_address = a; it.byte_count = n;
        it.write_byte = 8'($urandom); it.sda_in = 1'($urandom_range(0, 1));
        send_tick(it, gaps);
        guard = 0;
        while (m_st != S_IDLE && guard < 200000)
        begin
            send_tick(bus_tick(8'($urandom)), gaps);
            guard++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] a, input logic [31:0] v);
        drain();
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (a)
            REG_DEV:   m_dev = v[6:0];
            REG_PHASE: m_phase = v[7:0];
            default:   m_wait = v[15:0];
        endcase
    endtask

    task automatic test_directed();
        item_t it;
        nack_pct = 0;
        write_reg(REG_PHASE, 32'd1);
        write_reg(REG_WAIT, 32'd3);
        run_command(MODE_READ, 9'h000, 8'd0, 0);     // zero count
        run_command(MODE_PAGE, 9'h00e, 8'd3, 0);     // page crossing
        run_command(MODE_PAGE, 9'h1ff, 8'd2, 0);     // crossing at top
        run_command(MODE_READ, 9'h1fe, 8'd3, 0);     // wraps round
        run_command(MODE_SPLIT, 9'h10e, 8'd3, 0);    // split at boundary
        run_command(MODE_PAGE, 9'h0fc, 8'd4, 0);     // ends on page boundary
        it = '0; it.mode = 3'd7; it.mem_address = '1; it.byte_count = '1;
        it.write_byte = '1; it.sda_in = 1;
        send_tick(it, 0);                            // unused mode
        it.mode = MODE_WBYTE;
        send_tick(it, 0);                            // unwanted byte
        nack_pct = 100;
        run_command(MODE_READ, 9'h1aa, 8'd255, 0);   // no device ack
        write_reg(REG_PHASE, 32'd0);
        write_reg(REG_WAIT, 32'd0);
        run_command(MODE_SPLIT, 9'h055, 8'd2, 0);
        nack_pct = 0;
        run_command(MODE_SPLIT, 9'h0ff, 8'd2, 0);    // crosses into block one
        write_reg(REG_DEV, 32'h7f);
        run_command(MODE_READ, 9'h100, 8'd1, 0);
        write_reg(REG_DEV, 32'h00);
        run_command(MODE_PAGE, 9'h1f0, 8'd1, 0);
    endtask

    task automatic test_random(input int n_cmd);
        logic [2:0] md;
        logic [7:0] n;
        item_t it;
        repeat (n_cmd)
        begin
            md = 3'($urandom_range(MODE_READ, MODE_PAGE));
            n = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(6, 24))
                                             : 8'($urandom_range(0, 5));
            nack_pct = ($urandom_range(0, 3) == 0) ? 30 : 2;
            if ($urandom_range(0, 9) == 0)
            begin
                it = '0; it.mode = 3'($urandom); it.mem_address = 9'($urandom);
                it.byte_count = 8'($urandom_range(0, 3)); it.write_byte = 8'($urandom);
                it.sda_in = 1'($urandom);
                send_tick(it, 1);                    // noise
            end
            else run_command(md, 9'($urandom), n, 1);
        end
        // Noise may have opened a transaction: run it to the end
        while (m_st != S_IDLE) send_tick(bus_tick(8'($urandom)), 1);
    endtask

    task automatic test_wide_regs();
        nack_pct = 0;
        write_reg(REG_PHASE, 32'd255);
        write_reg(REG_WAIT, 32'd65535);
        run_command(MODE_PAGE, 9'h03f, 8'd2, 0);
        run_command(MODE_SPLIT, 9'h120, 8'd0, 0);
    endtask

    task automatic test_backpressure();
        logic [8:0] a;
        hold_cycles = 60;
        hold_rx = 1;
        nack_pct = 0;
        a = 9'($urandom);
        run_command(MODE_READ, a, 8'd2, 0);
        drain();
    endtask

    // ---- result checker and receiver ----
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.scl        = m_axis_tdata[0];
            got.sda_out    = m_axis_tdata[1];
            got.busy_res   = m_axis_tdata[2];
            got.want_byte  = m_axis_tdata[3];
            got.read_data  = m_axis_tdata[11:4];
            got.read_valid = m_axis_tdata[12];
            got.done_res   = m_axis_tdata[13];
            got.status     = m_axis_tdata[16:14];
            if (expected_q.size() == 0)
                report("unexpected result", int'(m_axis_tdata), 0);
            else
            begin
                want = expected_q.pop_front();
                if (got.scl != want.scl) report("scl", got.scl, want.scl);
                if (got.sda_out != want.sda_out) report("sda_out", got.sda_out, want.sda_out);
                if (got.busy_res != want.busy_res) report("busy", got.busy_res, want.busy_res);
                if (got.want_byte != want.want_byte)
                    report("want_byte", got.want_byte, want.want_byte);
                if (got.read_data != want.read_data)
                    report("read_data", got.read_data, want.read_data);
                if (got.read_valid != want.read_valid)
                    report("read_valid", got.read_valid, want.read_valid);
                if (got.done_res != want.done_res) report("done", got.done_res, want.done_res);
                if (got.status != want.status) report("status", got.status, want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_rx)
        begin
            m_axis_tready <= 0;
            if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
            else hold_rx <= 0;
        end
        else if (rx_gap > 0)
        begin
            m_axis_tready <= 0;
            rx_gap <= rx_gap - 1;
        end
        else if ($urandom_range(0, 99) < 95)
            m_axis_tready <= 1;
        else
        begin
            m_axis_tready <= 0;
            rx_gap <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 30);
        end
    end

    initial
    begin
        errors = 0; cycles = 0; hold_rx = 0; hold_cycles = 0; rx_gap = 0;
        rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        m_dev = 7'd80; m_phase = 8'd5; m_wait = 16'd5000;
        m_st = S_IDLE; m_stage = G_DEVW; m_pc = 0; m_bits = 0; m_sh = 0;
        m_addr = 0; m_rem = 0; m_page = 0; m_last = 0; m_job = 0; m_sda = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        write_reg(REG_PHASE, 32'd1);
        write_reg(REG_WAIT, 32'd2);
        write_reg(REG_DEV, 32'h50);
        test_random(2);
        test_wide_regs();
        write_reg(REG_PHASE, 32'd0);
        write_reg(REG_WAIT, 32'd1);
        write_reg(REG_DEV, 32'($urandom_range(0, 127)));
        test_random(1);
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
